// File: rtl/ppes_pkg.sv
package ppes_pkg;

   localparam int KeyWidth = 32;
   localparam int PrioWidth = 16;
   localparam int RepWidth = 16;
   localparam int TimeWidth = 32;
   localparam int ActWidth = 16;
   localparam int WordWidth = 32;
   localparam int StatusWidth = 3;

   localparam logic [1:0] OpSchedule = 2'd0;
   localparam logic [1:0] OpUnschedule = 2'd1;
   localparam logic [1:0] OpTick = 2'd2;

   localparam logic [2:0] StAdded = 3'd0;
   localparam logic [2:0] StUpdated = 3'd1;
   localparam logic [2:0] StFull = 3'd2;
   localparam logic [2:0] StRemoved = 3'd3;
   localparam logic [2:0] StNotFound = 3'd4;
   localparam logic [2:0] StFired = 3'd5;
   localparam logic [2:0] StTickDone = 3'd6;

   typedef struct packed {
      logic                 valid;
      logic [KeyWidth-1:0]  key;
      logic [PrioWidth-1:0] prio;
      logic [RepWidth-1:0]  repeats;
      logic [TimeWidth-1:0] period;
      logic [TimeWidth-1:0] remaining;
      logic [ActWidth-1:0]  action;
      logic [WordWidth-1:0] word;
   } entry_type;

   // Command broadcast from the sequencer to every cell for one cycle.  During a
   // tick scan the fresh entry carries the aged or reloaded head entry.
   typedef struct packed {
      logic                 insert;
      logic                 remove;
      logic                 update;
      logic                 scan;
      logic [KeyWidth-1:0]  key;
      entry_type            fresh;
   } cmd_type;

endpackage

// File: rtl/priority_periodic_event_scheduler.sv
// Channel  Direction  Handshake            Contents
// req      in         req_tvalid/tready    one command (schedule, unschedule, tick)
// rsp      out        rsp_tvalid/tready    status results, rsp_tlast on the final one
//
// Schedule and unschedule first capture the request, then every cell compares
// its key, the row updates in place and the single result is loaded into the
// output register.  A tick captures the request and then makes one scan step per
// stored entry: each step examines the head cell, the row shifts one step
// towards the head and the aged or reloaded entry rejoins at the tail unless it
// retires; a last step loads the done marker.
// Reset is synchronous and clears the valid bits and the entry count.  A result
// waiting in the output register holds any step that must emit one; the next
// request may be accepted while the final result of the last one still waits.
module priority_periodic_event_scheduler #(
   parameter int SLOTS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // op[1:0], key[33:2], priority_req[49:34], repeats[65:50], period[97:66],
   // action[113:98], user_word[145:114], elapsed[177:146], zeros[183:178]
   input  logic [183:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[2:0], fired_key[34:3], fired_action[50:35], fired_word[82:51],
   // retired[83], zeros[87:84]
   output logic [87:0]  rsp_tdata,
   output logic         rsp_tlast
);
   import ppes_pkg::*;

   typedef enum logic [1:0] {SIdle, SOp, SScan} state_type;

   localparam int IdxW = $clog2(SLOTS + 1);

   state_type state_ff;
   cmd_type   cmd;
   logic [1:0] op_ff;
   logic [KeyWidth-1:0] key_ff;
   logic [TimeWidth-1:0] elapsed_ff;
   entry_type fresh_ff;
   logic [IdxW-1:0] cnt_ff;       // number of valid entries in the row
   logic [IdxW-1:0] pos_ff;       // entries still to be scanned during a tick
   logic [2:0] st_ff;
   logic [KeyWidth-1:0] okey_ff;
   logic [ActWidth-1:0] oact_ff;
   logic [WordWidth-1:0] oword_ff;
   logic oret_ff, olast_ff, ovalid_ff;

   // Next values of the output register.
   logic out_load;
   logic [2:0] st_in;
   logic [KeyWidth-1:0] okey_in;
   logic [ActWidth-1:0] oact_in;
   logic [WordWidth-1:0] oword_in;
   logic oret_in, olast_in;

   entry_type ent [SLOTS];
   logic [SLOTS-1:0] prec, gon, hit, tail;

   logic any_hit;
   logic full;
   logic out_free;
   logic op_step;
   logic scan_step;
   logic head_due;
   logic head_retire;
   entry_type head_next;

   assign any_hit = |hit;
   assign full = (cnt_ff == IdxW'(SLOTS));
   // The output register can take a new result in this cycle.
   assign out_free = !ovalid_ff || rsp_tready;
   assign op_step = (state_ff == SOp) && out_free;

   // The head cell always holds the next entry of the scan.  An undue entry
   // needs no result, so it steps on even while the output register is full.
   assign head_due = ent[0].remaining <= elapsed_ff;
   assign head_retire = head_due && (ent[0].repeats == RepWidth'(1));
   assign scan_step = (state_ff == SScan) && (pos_ff != '0) && (!head_due || out_free);

   // The head entry after this tick: reloaded without the overshoot when due,
   // otherwise aged by the elapsed ticks.
   always_comb begin
      head_next = ent[0];
      if (head_due) begin
         head_next.remaining = ent[0].period;
         if (ent[0].repeats > RepWidth'(1)) head_next.repeats = ent[0].repeats - RepWidth'(1);
      end else begin
         head_next.remaining = ent[0].remaining - elapsed_ff;
      end
   end

   always_comb begin
      cmd.insert = op_step && op_ff == OpSchedule && !any_hit && !full;
      cmd.update = op_step && op_ff == OpSchedule && any_hit;
      cmd.remove = op_step && op_ff == OpUnschedule;
      cmd.scan = scan_step;
      cmd.key = key_ff;
      cmd.fresh = scan_step ? head_next : fresh_ff;
   end

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      entry_type le, re;
      logic lp, lg;
      if (g == 0) begin : g_first
         assign le = '0;
         assign lp = 1'b1;
         assign lg = 1'b0;
      end else begin : g_inner
         assign le = ent[g-1];
         assign lp = prec[g-1];
         assign lg = gon[g-1];
      end
      if (g == SLOTS - 1) begin : g_last
         assign re = '0;
      end else begin : g_body
         assign re = ent[g+1];
      end
      // A kept head entry rejoins behind the last valid entry after the shift.
      assign tail[g] = scan_step && !head_retire && (cnt_ff == IdxW'(g + 1));
      ppes_cell u_cell (
         .clock(clock), .reset(reset), .cmd(cmd), .left_entry(le),
         .left_precedes(lp), .left_gone(lg), .right_entry(re), .tail(tail[g]),
         .entry(ent[g]), .precedes(prec[g]), .gone(gon[g]), .key_hit(hit[g])
      );
   end

   // The result loaded into the output register in this cycle, if any.
   always_comb begin
      out_load = 1'b0;
      st_in = StAdded;
      okey_in = key_ff;
      oact_in = '0;
      oword_in = '0;
      oret_in = 1'b0;
      olast_in = 1'b1;
      case (state_ff)
         SOp: begin
            out_load = out_free;
            if (op_ff == OpSchedule)
               st_in = any_hit ? StUpdated : (full ? StFull : StAdded);
            else st_in = any_hit ? StRemoved : StNotFound;
         end
         SScan: begin
            if (pos_ff == '0) begin
               out_load = out_free;
               st_in = StTickDone;
               okey_in = '0;
            end else if (head_due) begin
               out_load = out_free;
               st_in = StFired;
               okey_in = ent[0].key;
               oact_in = ent[0].action;
               oword_in = ent[0].word;
               oret_in = head_retire;
               olast_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   assign req_tready = (state_ff == SIdle);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tlast = olast_ff;
   assign rsp_tdata = {4'b0, oret_ff, oword_ff, oact_ff, okey_ff, st_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SIdle;
         ovalid_ff <= 1'b0;
         cnt_ff <= '0;
         pos_ff <= '0;
      end else begin
         if (out_load) ovalid_ff <= 1'b1;
         else if (rsp_tready) ovalid_ff <= 1'b0;
         if (cmd.insert) cnt_ff <= cnt_ff + IdxW'(1);
         else if ((cmd.remove && any_hit) || (scan_step && head_retire))
            cnt_ff <= cnt_ff - IdxW'(1);
         case (state_ff)
            SIdle: begin
               if (req_tvalid) begin
                  op_ff <= req_tdata[1:0];
                  key_ff <= req_tdata[33:2];
                  fresh_ff.valid <= 1'b1;
                  fresh_ff.key <= req_tdata[33:2];
                  fresh_ff.prio <= req_tdata[49:34];
                  fresh_ff.repeats <= req_tdata[65:50];
                  fresh_ff.period <= req_tdata[97:66];
                  fresh_ff.remaining <= req_tdata[97:66];
                  fresh_ff.action <= req_tdata[113:98];
                  fresh_ff.word <= req_tdata[145:114];
                  elapsed_ff <= req_tdata[177:146];
                  pos_ff <= cnt_ff;
                  case (req_tdata[1:0])
                     OpSchedule, OpUnschedule: state_ff <= SOp;
                     OpTick: state_ff <= SScan;
                     default: state_ff <= SIdle;
                  endcase
               end
            end
            SOp: begin
               if (out_free) state_ff <= SIdle;
            end
            SScan: begin
               if (scan_step) pos_ff <= pos_ff - IdxW'(1);
               else if (pos_ff == '0 && out_free) state_ff <= SIdle;
            end
            default: state_ff <= SIdle;
         endcase
      end
      if (out_load) begin
         st_ff <= st_in;
         okey_ff <= okey_in;
         oact_ff <= oact_in;
         oword_ff <= oword_in;
         oret_ff <= oret_in;
         olast_ff <= olast_in;
      end
   end
endmodule

// File: rtl/ppes_cell.sv
module ppes_cell (
   input  logic                clock,
   input  logic                reset,
   input  ppes_pkg::cmd_type   cmd,
   input  ppes_pkg::entry_type left_entry,
   input  logic                left_precedes,
   input  logic                left_gone,
   input  ppes_pkg::entry_type right_entry,
   input  logic                tail,
   output ppes_pkg::entry_type entry,
   output logic                precedes,
   output logic                gone,
   output logic                key_hit
);
   import ppes_pkg::*;

   entry_type entry_ff, entry_in;

   assign entry = entry_ff;
   assign key_hit = entry_ff.valid && (entry_ff.key == cmd.key);
   // This cell precedes the new entry: it keeps its place on insertion.
   assign precedes = entry_ff.valid &&
      ($signed(entry_ff.prio) >= $signed(cmd.fresh.prio));
   // From the removed entry onwards every cell closes the gap.
   assign gone = left_gone || (cmd.remove && key_hit);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.update && key_hit) begin
         entry_in.action = cmd.fresh.action;
         entry_in.word = cmd.fresh.word;
      end else if (cmd.insert && !precedes) begin
         entry_in = left_precedes ? cmd.fresh : left_entry;
      end else if (cmd.remove && gone) begin
         entry_in = right_entry;
      end else if (cmd.scan) begin
         entry_in = tail ? cmd.fresh : right_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) entry_ff.valid <= 1'b0;
      else entry_ff.valid <= entry_in.valid;
      entry_ff.key <= entry_in.key;
      entry_ff.prio <= entry_in.prio;
      entry_ff.repeats <= entry_in.repeats;
      entry_ff.period <= entry_in.period;
      entry_ff.remaining <= entry_in.remaining;
      entry_ff.action <= entry_in.action;
      entry_ff.word <= entry_in.word;
   end
endmodule

// File: dv/priority_periodic_event_scheduler_tb.sv
module priority_periodic_event_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ppes_pkg::*;

   localparam int Slots = 32;
   localparam logic [1:0] OpUndefined = 2'd3;

   // One expected result of the scheduler.
   typedef struct {
      logic [2:0]  status;
      logic [31:0] key;
      logic [15:0] action;
      logic [31:0] word;
      logic        retired;
      logic        last;
   } event_result_type;

   // One table entry of the predictor.
   typedef struct {
      logic [31:0] key;
      logic [15:0] prio;
      logic [15:0] repeats;
      logic [31:0] period;
      logic [31:0] remaining;
      logic [15:0] action;
      logic [31:0] word;
   } timer_entry_type;

   // The scoreboard keeps its own copy of the timer table, works out the results of
   // each accepted request and compares the results of the block against them.
   class timer_table_scoreboard;
      timer_entry_type  table_q[$];
      event_result_type pending_q[$];
      int mismatches;
      int results_seen;
      int fired_seen;
      int retired_seen;
      int full_seen;

      function void push_result(logic [2:0] st, logic [31:0] k, logic [15:0] a,
                                logic [31:0] w, logic r, logic l);
         event_result_type e;
         e.status = st; e.key = k; e.action = a; e.word = w; e.retired = r; e.last = l;
         pending_q.push_back(e);
      endfunction

      function void note_request(logic [183:0] d);
         logic [1:0]   op;
         logic [31:0]  k;
         logic [15:0]  pr;
         logic [31:0]  el;
         timer_entry_type e;
         int pos;
         timer_entry_type kept_q[$];
         bit keep;
         op = d[1:0]; k = d[33:2]; pr = d[49:34]; el = d[177:146];
         e.key = k; e.prio = pr; e.repeats = d[65:50]; e.period = d[97:66];
         e.remaining = d[97:66]; e.action = d[113:98]; e.word = d[145:114];
         case (op)
            OpSchedule: begin
               foreach (table_q[i]) begin
                  if (table_q[i].key == k) begin
                     table_q[i].action = e.action;
                     table_q[i].word = e.word;
                     push_result(StUpdated, k, '0, '0, 1'b0, 1'b1);
                     return;
                  end
               end
               if (table_q.size() >= Slots) begin
                  push_result(StFull, k, '0, '0, 1'b0, 1'b1);
                  return;
               end
               // Equal priorities keep their order, so the newcomer goes behind them.
               pos = 0;
               while (pos < table_q.size() &&
                      $signed(table_q[pos].prio) >= $signed(pr)) pos++;
               table_q.insert(pos, e);
               push_result(StAdded, k, '0, '0, 1'b0, 1'b1);
            end
            OpUnschedule: begin
               foreach (table_q[i]) begin
                  if (table_q[i].key == k) begin
                     table_q.delete(i);
                     push_result(StRemoved, k, '0, '0, 1'b0, 1'b1);
                     return;
                  end
               end
               push_result(StNotFound, k, '0, '0, 1'b0, 1'b1);
            end
            OpTick: begin
               foreach (table_q[i]) begin
                  keep = 1;
                  e = table_q[i];
                  if (e.remaining <= el) begin
                     e.remaining = e.period;
                     if (e.repeats == 16'd1) keep = 0;
                     else if (e.repeats > 16'd1) e.repeats--;
                     push_result(StFired, e.key, e.action, e.word, !keep, 1'b0);
                  end else begin
                     e.remaining -= el;
                  end
                  if (keep) kept_q.push_back(e);
               end
               table_q = kept_q;
               push_result(StTickDone, '0, '0, '0, 1'b0, 1'b1);
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [87:0] d, logic l);
         event_result_type x;
         results_seen++;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result status=%0d key=%h", d[2:0], d[34:3]);
            return;
         end
         x = pending_q.pop_front();
         if (x.status == StFired) fired_seen++;
         if (x.retired) retired_seen++;
         if (x.status == StFull) full_seen++;
         if (d[2:0] !== x.status || d[34:3] !== x.key || d[50:35] !== x.action ||
             d[82:51] !== x.word || d[83] !== x.retired || l !== x.last ||
             d[87:84] !== 4'd0) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"ERROR: result mismatch: expected st=%0d key=%h act=%h ",
                         "word=%h ret=%b last=%b, got st=%0d key=%h act=%h ",
                         "word=%h ret=%b last=%b"},
                        x.status, x.key, x.action, x.word, x.retired, x.last,
                        d[2:0], d[34:3], d[50:35], d[82:51], d[83], l);
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [183:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [87:0]  rsp_tdata;
   logic         rsp_tlast;

   timer_table_scoreboard board = new();

   // Idle percentages of the sender and the receiver for the current phase.
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   // While set, the receiver holds off completely for a counted stretch.
   bit  hold_off = 0;
   int  requests_sent = 0;
   longint cycle_count = 0;
   // Keys in use, so that random requests often hit live entries.
   logic [31:0] key_pool[$];

   priority_periodic_event_scheduler #(.SLOTS(Slots)) uut (.*);

   always #5 clock = ~clock;

   // Requests and results are both taken on the rising edge; the scoreboard sees
   // them at that edge, before any stimulus changes on the falling edge.
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && req_tvalid && req_tready) board.note_request(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tlast);
      if (cycle_count > 2_000_000) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // The receiver decides its ready on each falling edge.
   always @(negedge clock) begin
      if (reset || hold_off) rsp_tready <= 0;
      else rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Sends one request, keeping valid high until it is accepted.  Valid stays high
   // on return so that the next request can follow at once; it drops on idling.
   task automatic send_request(logic [1:0] op, logic [31:0] k, logic [15:0] pr,
                               logic [15:0] reps, logic [31:0] per, logic [15:0] act,
                               logic [31:0] w, logic [31:0] el);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tdata <= {6'd0, el, w, act, per, reps, pr, k, op};
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      requests_sent++;
   endtask

   task automatic schedule_event(logic [31:0] k, logic [15:0] pr, logic [15:0] reps,
                                 logic [31:0] per);
      send_request(OpSchedule, k, pr, reps, per, 16'($urandom), $urandom, $urandom);
      key_pool.push_back(k);
   endtask

   task automatic random_request();
      int sel;
      logic [31:0] k;
      sel = $urandom_range(99);
      k = (key_pool.size() > 0 && $urandom_range(3) != 0) ?
          key_pool[$urandom_range(key_pool.size() - 1)] : $urandom;
      if (sel < 40)
         // Mostly short periods and small counts so that entries fire and retire.
         schedule_event(k, ($urandom_range(3) == 0) ? 16'($urandom) :
                           16'($signed($urandom_range(8)) - 4),
                        ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(3)),
                        ($urandom_range(9) == 0) ? $urandom : $urandom_range(40));
      else if (sel < 60)
         send_request(OpUnschedule, k, 16'($urandom), 16'($urandom), $urandom,
                      16'($urandom), $urandom, $urandom);
      else if (sel < 97)
         send_request(OpTick, $urandom, 16'($urandom), 16'($urandom), $urandom,
                      16'($urandom), $urandom,
                      ($urandom_range(19) == 0) ? $urandom : $urandom_range(15));
      else
         // The undefined operation must be ignored with no result.
         send_request(OpUndefined, k, 16'($urandom), 16'($urandom), $urandom,
                      16'($urandom), $urandom, $urandom);
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int phase;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed part: extremes of every field, each status and the corner cases.
      schedule_event(32'hFFFF_FFFF, 16'h7FFF, 16'hFFFF, 32'hFFFF_FFFF);
      schedule_event(32'h0, 16'h8000, 16'd1, 32'd0);
      schedule_event(32'h1234, 16'd0, 16'd0, 32'd3);
      schedule_event(32'h1235, 16'd0, 16'd2, 32'd3);
      send_request(OpSchedule, 32'h1234, 16'h7FFF, 16'd9, 32'd1, 16'hFFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OpTick, '0, '0, '0, '0, '0, '0, 32'd0);
      send_request(OpTick, '0, '0, '0, '0, '0, '0, 32'd5);
      send_request(OpTick, '0, '0, '0, '0, '0, '0, 32'd3);
      send_request(OpUnschedule, 32'h1235, '0, '0, '0, '0, '0, '0);
      send_request(OpUnschedule, 32'h1235, '0, '0, '0, '0, '0, '0);
      send_request(OpUndefined, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, '1, '1, '1, '1);
      send_request(OpTick, '0, '0, '0, '0, '0, '0, 32'hFFFF_FFFF);
      send_request(OpTick, '1, '1, '1, '1, '1, '1, 32'hFFFF_FFFE);
      // Fill the table to capacity, then one more to see the full status.
      for (int i = 0; i < Slots + 1; i++)
         schedule_event(32'(32'hA000_0000 + i), 16'($urandom_range(3)), 16'd1, 32'd2);
      // A full table in which every entry but key 1234 is due at once: the longest tick.
      send_request(OpTick, '0, '0, '0, '0, '0, '0, 32'd2);
      wait_drained();
      key_pool.delete();

      // Random part across idling phases.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
         endcase
         if (phase == 0) begin
            // The receiver holds off for a long stretch while requests keep coming.
            fork
               begin
                  hold_off = 1;
                  for (int c = 0; c < 600; c++) @(posedge clock);
                  hold_off = 0;
               end
            join_none
         end
         repeat (100) random_request();
         if (key_pool.size() > 60) key_pool = key_pool[key_pool.size()-30:$];
      end

      wait_drained();
      $display("Covered %0d requests and %0d results: %0d firings, %0d retirements,",
               requests_sent, board.results_seen, board.fired_seen, board.retired_seen);
      $display("and %0d full-table refusals.", board.full_seen);
      if (board.mismatches == 0 && board.pending_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
